// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// clocked assertion helpers used by the allocator unit
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/mfva_pkg.sv -----
// ----------------------------------------------------------------------------
// mfva_pkg
// types, codes and free list helpers of the four voice midi allocator
// ----------------------------------------------------------------------------
`default_nettype none

package mfva_pkg;

   localparam int VOICES  = 4;
   localparam int VOICE_W = $clog2(VOICES);
   localparam int COUNT_W = $clog2(VOICES + 1);

   // midi message types (high nibble of the status byte)
   localparam logic [3:0] MSG_NOTE_OFF      = 4'h8;
   localparam logic [3:0] MSG_NOTE_ON       = 4'h9;
   localparam logic [3:0] MSG_POLY_PRESSURE = 4'ha;
   localparam logic [3:0] MSG_CONTROL       = 4'hb;

   localparam logic [6:0] CC_SUSTAIN  = 7'h40;
   localparam logic [6:0] PEDAL_LEVEL = 7'd64;
   localparam logic [6:0] PITCH_RESET = 7'd60;

   // voice modes, every other code rotates
   localparam logic [1:0] MODE_RESET    = 2'd1;
   localparam logic [1:0] MODE_REASSIGN = 2'd2;

   // csr register indexes
   localparam logic CSR_CHANNEL_FILTER = 1'b0;
   localparam logic CSR_VOICE_MODE     = 1'b1;

   typedef logic [VOICE_W-1:0] voice_id_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef struct packed {
      voice_id_type [VOICES-1:0] order;
      count_type                 count;
   } free_list_type;

   function automatic free_list_type list_init(free_list_type fl);
      free_list_type res;
      res = fl;
      for (int i = 0; i < VOICES; i++) begin
         res.order[i] = VOICE_W'(i);
      end
      res.count = COUNT_W'(VOICES);
      return res;
   endfunction

   function automatic free_list_type list_remove(free_list_type fl, voice_id_type v);
      free_list_type res;
      count_type     w;
      res = fl;
      w   = '0;
      for (int r = 0; r < VOICES; r++) begin
         if (COUNT_W'(r) < fl.count && fl.order[r] != v) begin
            res.order[w[VOICE_W-1:0]] = fl.order[r];
            w = w + 1'b1;
         end
      end
      res.count = w;
      return res;
   endfunction

   function automatic free_list_type list_push_front(free_list_type fl, voice_id_type v);
      free_list_type tmp;
      free_list_type res;
      tmp = list_remove(fl, v);
      if (tmp.count >= COUNT_W'(VOICES)) begin
         tmp.count = COUNT_W'(VOICES - 1);
      end
      res = tmp;
      for (int k = 1; k < VOICES; k++) begin
         if (COUNT_W'(k) <= tmp.count) begin
            res.order[k] = tmp.order[k-1];
         end
      end
      res.order[0] = v;
      res.count    = tmp.count + 1'b1;
      return res;
   endfunction

   // entries are distinct voice ids, so sorting is a compaction of the member set
   function automatic free_list_type list_sort(free_list_type fl);
      free_list_type       res;
      logic [VOICES-1:0]   member;
      count_type           w;
      res    = fl;
      member = '0;
      w      = '0;
      for (int r = 0; r < VOICES; r++) begin
         if (COUNT_W'(r) < fl.count) begin
            member[fl.order[r]] = 1'b1;
         end
      end
      for (int v = 0; v < VOICES; v++) begin
         if (member[v]) begin
            res.order[w[VOICE_W-1:0]] = VOICE_W'(v);
            w = w + 1'b1;
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/midi_four_voice_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// midi_four_voice_allocator_unit
// polyphonic midi voice allocator: channel filter, note on/off, key pressure,
// sustain pedal, free voice list; four voice records per message
// ----------------------------------------------------------------------------
//
// channel | direction | payload
// --------+-----------+--------------------------------------------------------
// req_    | in        | tuser action, tdata status/data_first/data_second
// rsp_    | out       | tuser voice_index, tdata voice record, tlast last voice
// csr_    | in        | index 0 channel_filter, 1 voice_mode
//
// a message transfer lands in the input register; when the prior record run is
// done or ends, the whole state update runs in one pass and loads the voice state
// registers; four records follow, one per cycle while rsp_tready is high, read
// straight from the voice registers; the output sequencer holds each update until
// the last record goes out; the input register takes the next message as records go out
// synchronous active high reset restores the voice state and the csr defaults
// a stalled rsp_ side holds the record and the voice state unchanged
//
`default_nettype none

`include "assert_macros.svh"

module midi_four_voice_allocator_unit
   import mfva_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // status_byte[7:0], data_first[14:8], data_second[21:15]
   input  wire logic        req_tuser,   // action

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // note_pitch[6:0], gate_on[7], note_velocity[14:8],
                                         // key_pressure[21:15]
   output logic [1:0]       rsp_tuser,   // voice_index
   output logic             rsp_tlast,   // last_voice

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [4:0]  csr_data
);

   // configuration
   logic [4:0] channel_filter_ff;
   logic [1:0] voice_mode_ff;

   // input register
   logic       in_valid_ff;
   logic       in_action_ff;
   logic [7:0] in_status_ff;
   logic [6:0] in_d1_ff;
   logic [6:0] in_d2_ff;

   // voice state
   logic [VOICES-1:0][6:0]    voice_pitch_ff,    voice_pitch_in;
   logic [VOICES-1:0]         voice_gate_ff,     voice_gate_in;
   logic [VOICES-1:0][6:0]    voice_velocity_ff, voice_velocity_in;
   logic [VOICES-1:0][6:0]    voice_pressure_ff, voice_pressure_in;
   logic [VOICES-1:0]         pending_ff,        pending_in;
   logic                      sustain_ff,        sustain_in;
   voice_id_type [VOICES-1:0] free_order_ff,     free_order_in;
   count_type                 free_count_ff,     free_count_in;

   // output sequencer
   logic         out_busy_ff;
   voice_id_type out_idx_ff;

   logic          proc_fire;
   logic          last_xfer;
   logic          chan_ok;
   logic          do_off;
   logic          do_on;
   logic          do_press;
   logic          do_pedal;
   free_list_type fl_work;
   free_list_type fl_shift;
   voice_id_type  next_v;

   // ---------------------------------------------------------------------------
   // handshakes
   // ---------------------------------------------------------------------------
   assign csr_ready  = 1'b1;
   assign last_xfer  = out_busy_ff && rsp_tready && (out_idx_ff == VOICE_W'(VOICES - 1));
   // process when the record run is done or ends this cycle
   assign proc_fire  = in_valid_ff && (!out_busy_ff || last_xfer);
   assign req_tready = !in_valid_ff || proc_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_filter_ff <= 5'h1f;        // accept every channel
         voice_mode_ff     <= MODE_REASSIGN;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CHANNEL_FILTER: channel_filter_ff <= csr_data;
            CSR_VOICE_MODE:     voice_mode_ff     <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (proc_fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_action_ff <= req_tuser;
         in_status_ff <= req_tdata[7:0];
         in_d1_ff     <= req_tdata[14:8];
         in_d2_ff     <= req_tdata[21:15];
      end
   end

   // ---------------------------------------------------------------------------
   // message decode
   // ---------------------------------------------------------------------------
   // negative filter (sign bit set) takes every channel
   assign chan_ok  = channel_filter_ff[4] || (channel_filter_ff[3:0] == in_status_ff[3:0]);
   // note on with velocity zero counts as note off
   assign do_off   = !in_action_ff && chan_ok &&
                     ((in_status_ff[7:4] == MSG_NOTE_OFF) ||
                      ((in_status_ff[7:4] == MSG_NOTE_ON) && (in_d2_ff == 7'd0)));
   assign do_on    = !in_action_ff && chan_ok &&
                     (in_status_ff[7:4] == MSG_NOTE_ON) && (in_d2_ff != 7'd0);
   assign do_press = !in_action_ff && chan_ok && (in_status_ff[7:4] == MSG_POLY_PRESSURE);
   assign do_pedal = !in_action_ff && chan_ok &&
                     (in_status_ff[7:4] == MSG_CONTROL) && (in_d1_ff == CC_SUSTAIN);

   // ---------------------------------------------------------------------------
   // single pass state update
   // ---------------------------------------------------------------------------
   always_comb begin
      voice_pitch_in    = voice_pitch_ff;
      voice_gate_in     = voice_gate_ff;
      voice_velocity_in = voice_velocity_ff;
      voice_pressure_in = voice_pressure_ff;
      pending_in        = pending_ff;
      sustain_in        = sustain_ff;
      fl_work.order     = free_order_ff;
      fl_work.count     = free_count_ff;
      fl_shift          = fl_work;
      next_v            = '0;

      if (in_action_ff) begin
         // clear keeps pitches and pending marks
         voice_gate_in     = '0;
         voice_velocity_in = '0;
         voice_pressure_in = '0;
         sustain_in        = 1'b0;
         fl_work.count     = '0;
      end else if (do_press) begin
         for (int i = 0; i < VOICES; i++) begin
            if (voice_pitch_ff[i] == in_d1_ff) begin
               voice_pressure_in[i] = in_d2_ff;
            end
         end
      end else if (do_pedal) begin
         sustain_in = (in_d2_ff >= PEDAL_LEVEL);
         if (!sustain_in) begin
            // pedal up: release every pending voice, even with the pedal already up
            for (int i = 0; i < VOICES; i++) begin
               if (pending_ff[i]) begin
                  pending_in[i]    = 1'b0;
                  voice_gate_in[i] = 1'b0;
                  fl_work          = list_push_front(fl_work, VOICE_W'(i));
               end
            end
         end
      end else if (do_off) begin
         for (int i = 0; i < VOICES; i++) begin
            if (voice_pitch_ff[i] == in_d1_ff && voice_gate_ff[i]) begin
               if (sustain_ff) begin
                  pending_in[i] = 1'b1;
               end else begin
                  voice_velocity_in[i] = in_d2_ff;
                  voice_gate_in[i]     = 1'b0;
                  fl_work              = list_push_front(fl_work, VOICE_W'(i));
               end
            end
         end
      end else if (do_on) begin
         if (fl_work.count == '0) begin
            fl_work = list_init(fl_work);
         end
         if (!(|voice_gate_ff)) begin
            fl_work = list_sort(fl_work);
         end
         if (voice_mode_ff == MODE_RESET && fl_work.count >= COUNT_W'(VOICES)) begin
            fl_work       = list_init(fl_work);
            voice_gate_in = '0;
         end

         // take the head of the list
         next_v   = fl_work.order[0];
         fl_shift = fl_work;
         for (int k = 1; k < VOICES; k++) begin
            if (COUNT_W'(k) < fl_work.count) begin
               fl_shift.order[k-1] = fl_work.order[k];
            end
         end
         if (voice_mode_ff == MODE_REASSIGN) begin
            // head goes to the tail, list length unchanged
            fl_shift.order[VOICE_W'(fl_work.count - 1'b1)] = next_v;
         end else begin
            fl_shift.count = fl_work.count - 1'b1;
         end
         fl_work = fl_shift;

         // retrigger: a voice already sounding this pitch is freed first
         for (int i = 0; i < VOICES; i++) begin
            if (voice_pitch_ff[i] == in_d1_ff && voice_gate_in[i]) begin
               voice_velocity_in[i] = in_d2_ff;
               fl_work              = list_push_front(fl_work, VOICE_W'(i));
               voice_gate_in[i]     = 1'b0;
               pending_in[i]        = 1'b0;
            end
         end

         voice_gate_in[next_v]     = 1'b1;
         pending_in[next_v]        = 1'b0;
         voice_pitch_in[next_v]    = in_d1_ff;
         voice_velocity_in[next_v] = in_d2_ff;
      end

      free_order_in = fl_work.order;
      free_count_in = fl_work.count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         voice_pitch_ff    <= {VOICES{PITCH_RESET}};
         voice_gate_ff     <= '0;
         voice_velocity_ff <= '0;
         voice_pressure_ff <= '0;
         pending_ff        <= '0;
         sustain_ff        <= 1'b0;
         free_count_ff     <= '0;
      end else if (proc_fire) begin
         voice_pitch_ff    <= voice_pitch_in;
         voice_gate_ff     <= voice_gate_in;
         voice_velocity_ff <= voice_velocity_in;
         voice_pressure_ff <= voice_pressure_in;
         pending_ff        <= pending_in;
         sustain_ff        <= sustain_in;
         free_count_ff     <= free_count_in;
      end
   end

   // list entries past the count are never read, so no reset here
   always_ff @(posedge clock) begin
      if (proc_fire) begin
         free_order_ff <= free_order_in;
      end
   end

   // ---------------------------------------------------------------------------
   // record sequencer
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_busy_ff <= 1'b0;
         out_idx_ff  <= '0;
      end else if (proc_fire) begin
         out_busy_ff <= 1'b1;
         out_idx_ff  <= '0;
      end else if (out_busy_ff && rsp_tready) begin
         if (out_idx_ff == VOICE_W'(VOICES - 1)) begin
            out_busy_ff <= 1'b0;
         end else begin
            out_idx_ff <= out_idx_ff + 1'b1;
         end
      end
   end

   assign rsp_tvalid = out_busy_ff;
   assign rsp_tuser  = out_idx_ff;
   assign rsp_tlast  = (out_idx_ff == VOICE_W'(VOICES - 1));
   assign rsp_tdata  = {2'b00,
                        voice_pressure_ff[out_idx_ff],
                        voice_velocity_ff[out_idx_ff],
                        voice_gate_ff[out_idx_ff],
                        voice_pitch_ff[out_idx_ff]};

   // ---------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------
   `ASSERT_CLK(a_count_range, clock, reset, free_count_ff <= COUNT_W'(VOICES), "free count overflow")
   `ASSERT_CLK(a_no_overrun, clock, reset, proc_fire |-> (!out_busy_ff || last_xfer), "state update during record run")
   `ASSERT_NEXT(a_run_start, clock, reset, proc_fire, rsp_tvalid && out_idx_ff == '0, "record run did not start at voice zero")
   `ASSERT_NEXT(a_idx_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(out_idx_ff), "record index moved while stalled")

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the four voice midi allocator: drives midi messages
// and clear actions, predicts the four voice records of every message from its
// own copy of the voice state and compares each record field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import mfva_pkg::*;

   localparam int STALL_LIMIT = 2000;   // cycles with no transfer at all
   localparam int SETTLE      = 8;      // input register, update pass, sequencer
   localparam int SHOWN_MAX   = 10;

   localparam logic ACT_MIDI  = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   // mode 0 and the unused code 3 both rotate
   localparam logic [1:0] MODE_ROTATE = 2'd0;
   localparam logic [1:0] MODE_SPARE  = 2'd3;

   localparam logic signed [4:0] OMNI = -5'sd1;

   typedef struct packed {
      logic [1:0] voice;
      logic [6:0] pitch;
      logic       gate;
      logic [6:0] velocity;
      logic [6:0] pressure;
      logic       last;
   } voice_record_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // status_byte[7:0], data_first[14:8], data_second[21:15]
   logic        req_tuser;   // action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;   // note_pitch[6:0], gate_on[7], note_velocity[14:8],
                             // key_pressure[21:15]
   logic [1:0]  rsp_tuser;   // voice_index
   logic        rsp_tlast;   // last_voice
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [4:0]  csr_data;

   // when set, neither side idles
   bit steady_flow = 1'b0;

   int mismatches = 0;
   int stall_cycles = 0;

   voice_record_type records_due[$];

   // predicted voice state
   logic [6:0]        v_pitch    [VOICES];
   logic              v_gate     [VOICES];
   logic [6:0]        v_velocity [VOICES];
   logic [6:0]        v_pressure [VOICES];
   logic              v_pending  [VOICES];
   logic              pedal_down;
   voice_id_type      free_ids   [VOICES];
   count_type         free_n;
   logic signed [4:0] chan_filter;
   logic [1:0]        assign_mode;

   always #4 clock = ~clock;

   midi_four_voice_allocator_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // ---------------------------------------------------------------------
   // voice state predictor
   // ---------------------------------------------------------------------

   // entries at or beyond free_n are don't-care
   function automatic void free_drop(voice_id_type v);
      count_type w;
      w = '0;
      for (int r = 0; r < free_n; r++) begin
         if (free_ids[r] != v) begin
            free_ids[w] = free_ids[r];
            w++;
         end
      end
      free_n = w;
   endfunction

   // the voice goes to the head, taken out first so it appears once
   function automatic void free_to_front(voice_id_type v);
      free_drop(v);
      if (free_n >= VOICES) begin
         free_n = count_type'(VOICES - 1);
      end
      for (int k = free_n; k > 0; k--) begin
         free_ids[k] = free_ids[k-1];
      end
      free_ids[0] = v;
      free_n++;
   endfunction

   function automatic void free_sort_ascending();
      voice_id_type x;
      int j;
      for (int i = 1; i < free_n; i++) begin
         x = free_ids[i];
         j = i;
         while (j > 0 && free_ids[j-1] > x) begin
            free_ids[j] = free_ids[j-1];
            j--;
         end
         free_ids[j] = x;
      end
   endfunction

   function automatic void gate_off(int i);
      v_gate[i] = 1'b0;
      free_to_front(voice_id_type'(i));
   endfunction

   function automatic void start_note(logic [6:0] key, logic [6:0] vel);
      logic         sounding;
      voice_id_type nxt;
      if (free_n == 0) begin
         for (int i = 0; i < VOICES; i++) free_ids[i] = voice_id_type'(i);
         free_n = count_type'(VOICES);
      end
      sounding = 1'b0;
      for (int i = 0; i < VOICES; i++) sounding |= v_gate[i];
      if (!sounding) free_sort_ascending();
      if (assign_mode == MODE_RESET && free_n >= VOICES) begin
         for (int i = 0; i < VOICES; i++) begin
            free_ids[i] = voice_id_type'(i);
            v_gate[i]   = 1'b0;
         end
         free_n = count_type'(VOICES);
      end
      // pop the head; reassign mode puts it straight back at the tail
      nxt = free_ids[0];
      for (int k = 1; k < free_n; k++) free_ids[k-1] = free_ids[k];
      if (assign_mode == MODE_REASSIGN) begin
         free_ids[free_n - 1] = nxt;
      end else begin
         free_n--;
      end
      // a retriggered pitch drops the voice that already held it
      for (int i = 0; i < VOICES; i++) begin
         if (v_pitch[i] == key && v_gate[i]) begin
            v_velocity[i] = vel;
            free_to_front(voice_id_type'(i));
            v_gate[i]    = 1'b0;
            v_pending[i] = 1'b0;
         end
      end
      v_gate[nxt]     = 1'b1;
      v_pending[nxt]  = 1'b0;
      v_pitch[nxt]    = key;
      v_velocity[nxt] = vel;
   endfunction

   function automatic void take_message(logic [7:0] status, logic [6:0] d1, logic [6:0] d2);
      if (!chan_filter[4] && chan_filter[3:0] != status[3:0]) return;
      case (status[7:4])
         MSG_NOTE_OFF, MSG_NOTE_ON: begin
            if (status[7:4] == MSG_NOTE_ON && d2 != 0) begin
               start_note(d1, d2);
               return;
            end
            for (int i = 0; i < VOICES; i++) begin
               if (v_pitch[i] == d1 && v_gate[i]) begin
                  if (pedal_down) begin
                     v_pending[i] = 1'b1;
                  end else begin
                     v_velocity[i] = d2;
                     gate_off(i);
                  end
               end
            end
         end
         MSG_POLY_PRESSURE: begin
            for (int i = 0; i < VOICES; i++) begin
               if (v_pitch[i] == d1) v_pressure[i] = d2;
            end
         end
         MSG_CONTROL: begin
            if (d1 == CC_SUSTAIN) begin
               pedal_down = (d2 >= PEDAL_LEVEL);
               // pedal up flushes pending releases, even when already up
               if (!pedal_down) begin
                  for (int i = 0; i < VOICES; i++) begin
                     if (v_pending[i]) begin
                        v_pending[i] = 1'b0;
                        gate_off(i);
                     end
                  end
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void step_voices(logic act, logic [23:0] payload);
      voice_record_type rec;
      if (act == ACT_CLEAR) begin
         // pitches and pending flags survive a clear
         for (int i = 0; i < VOICES; i++) begin
            v_gate[i]     = 1'b0;
            v_velocity[i] = '0;
            v_pressure[i] = '0;
         end
         free_n     = '0;
         pedal_down = 1'b0;
      end else begin
         take_message(payload[7:0], payload[14:8], payload[21:15]);
      end
      for (int i = 0; i < VOICES; i++) begin
         rec = '{voice: 2'(i), pitch: v_pitch[i], gate: v_gate[i],
                 velocity: v_velocity[i], pressure: v_pressure[i],
                 last: (i == VOICES - 1)};
         records_due = {records_due, rec};
      end
   endfunction

   function automatic void reset_voices();
      for (int i = 0; i < VOICES; i++) begin
         v_pitch[i]    = PITCH_RESET;
         v_gate[i]     = 1'b0;
         v_velocity[i] = '0;
         v_pressure[i] = '0;
         v_pending[i]  = 1'b0;
         free_ids[i]   = '0;
      end
      pedal_down  = 1'b0;
      free_n      = '0;
      chan_filter = OMNI;
      assign_mode = MODE_REASSIGN;
   endfunction

   // ---------------------------------------------------------------------
   // record checker, predictor feed and watchdog, all at the rising edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      voice_record_type got;
      voice_record_type want;
      if (!reset) begin
         // input transfers first: no record can belong to a message taken this edge
         if (req_tvalid && req_tready) step_voices(req_tuser, req_tdata);
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_CHANNEL_FILTER) begin
               chan_filter = csr_data;
            end else begin
               assign_mode = csr_data[1:0];
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{voice: rsp_tuser, pitch: rsp_tdata[6:0], gate: rsp_tdata[7],
                    velocity: rsp_tdata[14:8], pressure: rsp_tdata[21:15],
                    last: rsp_tlast};
            if (records_due.size() == 0) begin
               mismatches++;
               if (mismatches <= SHOWN_MAX) begin
                  $display("%0t: voice record with none expected: voice %0d pitch %0d",
                           $realtime, got.voice, got.pitch);
               end
            end else begin
               want = records_due[0];
               records_due.delete(0);
               if (got.voice != want.voice || got.pitch != want.pitch ||
                   got.gate != want.gate || got.velocity != want.velocity ||
                   got.pressure != want.pressure || got.last != want.last) begin
                  mismatches++;
                  if (mismatches <= SHOWN_MAX) begin
                     $display("%0t: record mismatch voice/pitch/gate/vel/press/last", $realtime);
                     $display("   expected %0d %0d %0b %0d %0d %0b", want.voice, want.pitch,
                              want.gate, want.velocity, want.pressure, want.last);
                     $display("   actual   %0d %0d %0b %0d %0d %0b", got.voice, got.pitch,
                              got.gate, got.velocity, got.pressure, got.last);
                  end
               end
            end
         end
         // watchdog: any transfer on any channel restarts the count
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // receiver stalls at random unless the steady stretch is on
   always @(posedge clock) begin
      rsp_tready <= steady_flow || ($urandom_range(0, 99) >= 18);
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // valid stays high after the transfer so back to back items never
   // lower and raise it in one step; drain_records drops it
   task automatic send_msg(input logic act, input logic [7:0] status,
                           input logic [6:0] d1, input logic [6:0] d2);
      if (!steady_flow && $urandom_range(0, 99) < 18) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 18);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {2'b00, d2, d1, status};
      do @(posedge clock); while (!req_tready);
   endtask

   // sender holds off until every predicted record has come back
   task automatic drain_records();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (records_due.size() != 0) @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // both registers, only while the block is idle; spare mode bits get noise
   task automatic program_regs(input logic signed [4:0] filter, input logic [1:0] mode);
      csr_valid <= 1'b1;
      csr_index <= CSR_CHANNEL_FILTER;
      csr_data  <= filter;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_VOICE_MODE;
      csr_data  <= {3'($urandom_range(0, 7)), mode};
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // mostly well-formed playing on a narrow key range so offs, retriggers
   // and pressure hit held voices; the rest is clears and raw noise
   task automatic play_phrase(input int count, input logic signed [4:0] filter);
      logic [6:0] base;
      logic [6:0] key;
      logic [3:0] ch;
      int         pick;
      base = 7'($urandom_range(0, 120));
      repeat (count) begin
         key  = base + 7'($urandom_range(0, 7));
         ch   = (filter < 0 || $urandom_range(0, 9) == 0) ? 4'($urandom) : filter[3:0];
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            send_msg(ACT_MIDI, {MSG_NOTE_ON, ch}, key, 7'($urandom_range(1, 127)));
         end else if (pick < 55) begin
            send_msg(ACT_MIDI, {MSG_NOTE_OFF, ch}, key, 7'($urandom));
         end else if (pick < 62) begin
            send_msg(ACT_MIDI, {MSG_NOTE_ON, ch}, key, 7'd0);
         end else if (pick < 72) begin
            send_msg(ACT_MIDI, {MSG_CONTROL, ch}, CC_SUSTAIN, 7'($urandom));
         end else if (pick < 80) begin
            send_msg(ACT_MIDI, {MSG_POLY_PRESSURE, ch}, key, 7'($urandom));
         end else if (pick < 84) begin
            send_msg(ACT_CLEAR, 8'($urandom), 7'($urandom), 7'($urandom));
         end else begin
            send_msg(ACT_MIDI, 8'($urandom), 7'($urandom), 7'($urandom));
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // reset configuration: every channel, reassign mode
   task automatic test_directed();
      send_msg(ACT_MIDI, {MSG_NOTE_ON, 4'h0}, 7'd0, 7'd127);
      send_msg(ACT_MIDI, {MSG_NOTE_ON, 4'hf}, 7'd127, 7'd1);
      send_msg(ACT_MIDI, {MSG_POLY_PRESSURE, 4'h3}, 7'd127, 7'd127);
      // voices still at the reset pitch pick this up too
      send_msg(ACT_MIDI, {MSG_POLY_PRESSURE, 4'h3}, PITCH_RESET, 7'h55);
      // pedal down, then a note off only marks the voice pending
      send_msg(ACT_MIDI, {MSG_CONTROL, 4'h3}, CC_SUSTAIN, 7'd127);
      send_msg(ACT_MIDI, {MSG_NOTE_OFF, 4'h0}, 7'd0, 7'd99);
      send_msg(ACT_MIDI, {MSG_CONTROL, 4'h0}, CC_SUSTAIN, 7'd63);
      // pedal up while already up
      send_msg(ACT_MIDI, {MSG_CONTROL, 4'h0}, CC_SUSTAIN, 7'd0);
      send_msg(ACT_MIDI, {MSG_CONTROL, 4'h0}, 7'd1, 7'd127);
      // velocity zero note on releases
      send_msg(ACT_MIDI, {MSG_NOTE_ON, 4'h5}, 7'd127, 7'd0);
      // message types with no effect
      send_msg(ACT_MIDI, 8'hc0, 7'd5, 7'd5);
      send_msg(ACT_MIDI, 8'hf0, 7'd127, 7'd127);
      send_msg(ACT_MIDI, 8'h00, 7'd0, 7'd0);
      send_msg(ACT_MIDI, 8'h7f, 7'd127, 7'd127);
      send_msg(ACT_MIDI, 8'he5, 7'd64, 7'd64);
      // fill all four voices and then steal one
      send_msg(ACT_MIDI, {MSG_NOTE_ON, 4'h1}, 7'd36, 7'd10);
      send_msg(ACT_MIDI, {MSG_NOTE_ON, 4'h1}, 7'd40, 7'd20);
      send_msg(ACT_MIDI, {MSG_NOTE_ON, 4'h1}, 7'd43, 7'd30);
      send_msg(ACT_MIDI, {MSG_NOTE_ON, 4'h1}, 7'd47, 7'd40);
      send_msg(ACT_MIDI, {MSG_NOTE_ON, 4'h1}, 7'd50, 7'd50);
      // retrigger of a held pitch
      send_msg(ACT_MIDI, {MSG_NOTE_ON, 4'h1}, 7'd50, 7'd126);
      send_msg(ACT_MIDI, {MSG_CONTROL, 4'h2}, CC_SUSTAIN, PEDAL_LEVEL);
      // clear ignores the payload, every bit set
      send_msg(ACT_CLEAR, 8'hff, 7'h7f, 7'h7f);
      send_msg(ACT_MIDI, {MSG_NOTE_ON, 4'h2}, 7'd60, 7'd64);
      drain_records();
   endtask

   task automatic test_channel_filter();
      program_regs(5'sd5, MODE_REASSIGN);
      send_msg(ACT_MIDI, {MSG_NOTE_ON, 4'h5}, 7'd70, 7'd90);
      send_msg(ACT_MIDI, {MSG_NOTE_ON, 4'h6}, 7'd71, 7'd90);
      send_msg(ACT_MIDI, {MSG_NOTE_OFF, 4'h6}, 7'd70, 7'd1);
      send_msg(ACT_MIDI, {MSG_NOTE_OFF, 4'h5}, 7'd70, 7'd2);
      drain_records();
   endtask

   // each policy, with the filter at its extremes along the way
   task automatic test_voice_modes();
      program_regs(5'sd0, MODE_ROTATE);
      play_phrase(55, 5'sd0);
      drain_records();
      program_regs(5'sd15, MODE_RESET);
      play_phrase(55, 5'sd15);
      drain_records();
      program_regs(-5'sd16, MODE_REASSIGN);
      play_phrase(55, -5'sd16);
      drain_records();
      program_regs(5'sd9, MODE_SPARE);
      play_phrase(55, 5'sd9);
      drain_records();
   endtask

   // back to back traffic with both sides always ready
   task automatic test_steady_stream();
      program_regs(OMNI, MODE_REASSIGN);
      steady_flow = 1'b1;
      play_phrase(100, OMNI);
      drain_records();
      steady_flow = 1'b0;
   endtask

   initial begin
      reset_voices();
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= ACT_MIDI;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_CHANNEL_FILTER;
      csr_data   <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_channel_filter();
      test_voice_modes();
      test_steady_stream();

      if (mismatches == 0 && records_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- midi_four_voice_allocator_unit.f -----
+incdir+hdl
hdl/mfva_pkg.sv
hdl/midi_four_voice_allocator_unit.sv
dv/tb.sv
